// ----- src/assert_macros.svh -----
// assertion macros shared by the rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked on every rising edge outside reset
`define ASSERT_IMP(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

`endif

// ----- src/one_pkg.sv -----
// package for the octahedral normal encoder
// constants, register indexes and mode codes; no dependencies
package one_pkg;
    localparam int COMPONENT_BITS_DEF = 16;
    localparam int QW = 16;
    localparam int QBITS_PER_STAGE = 2;
    localparam int NSTG = QW / QBITS_PER_STAGE;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_ENCODE_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_LEN_SQ = 2'd1;

    localparam logic [1:0] MODE_OCT16 = 2'd0;
    localparam logic [1:0] MODE_OCT32 = 2'd1;
    localparam logic [1:0] MODE_TANGENT = 2'd2;

    localparam logic [1:0] MODE_RST = MODE_OCT16;
    localparam logic [31:0] MIN_LEN_SQ_RST = 32'd11;
endpackage

// ----- src/octahedral_normal_encode.sv -----
// octahedral normal encoder, top level
// depends on one_pkg and assert_macros.svh
//
//  channel   direction  signals
//  in        sink       i_in_valid / o_in_ready, x y z, bitangent sign
//  out       source     o_out_valid / i_out_ready, packed code, degenerate flag
//  cfg       sink       i_cfg_valid / o_cfg_ready, index, data
//
// one transaction per cycle while the out channel does not stall; 4 front stages, 8 divider stages
// the divider retires 2 quotient bits per stage for both axes in parallel
// a stall on the out channel freezes the whole pipeline, nothing lost or repeated
// reset clears valid bits and config registers; no clearing pass
`include "assert_macros.svh"

module octahedral_normal_encode
    import one_pkg::*;
#(
    parameter int COMPONENT_BITS = COMPONENT_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [COMPONENT_BITS-1:0] i_normal_x,
    input  logic [COMPONENT_BITS-1:0] i_normal_y,
    input  logic [COMPONENT_BITS-1:0] i_normal_z,
    input  logic                      i_bitangent_negative,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [31:0]               o_packed_code,
    output logic                      o_degenerate,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [31:0]               i_cfg_data
);
    localparam int CW = COMPONENT_BITS;
    localparam int LW = CW + 1;
    localparam int NW = CW + 2;
    localparam int RW = NW + 1;
    localparam int DVW = NW + QW;
    localparam int SQW = 2 * CW + 2;
    localparam int NS = NSTG + 4;

    logic [1:0]  r_mode;
    logic [31:0] r_min_sq;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_RST;
            r_min_sq <= MIN_LEN_SQ_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_ENCODE_MODE: r_mode <= i_cfg_data[1:0];
                REG_MIN_LEN_SQ:  r_min_sq <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic r_vld [NS];
    logic en;
    assign en = !r_vld[NS-1] || i_out_ready;
    assign o_in_ready = en;
    assign o_out_valid = r_vld[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NS; i++) r_vld[i] <= 1'b0;
        end else if (en) begin
            r_vld[0] <= i_in_valid;
            for (int i = 1; i < NS; i++) r_vld[i] <= r_vld[i-1];
        end
    end

    // stage 1: magnitudes and signs
    logic [CW-1:0] r_s1_ax, r_s1_ay, r_s1_az;
    logic r_s1_nx, r_s1_ny, r_s1_zn, r_s1_sg;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_ax <= i_normal_x[CW-1] ? CW'(-i_normal_x) : i_normal_x;
            r_s1_ay <= i_normal_y[CW-1] ? CW'(-i_normal_y) : i_normal_y;
            r_s1_az <= i_normal_z[CW-1] ? CW'(-i_normal_z) : i_normal_z;
            r_s1_nx <= i_normal_x[CW-1];
            r_s1_ny <= i_normal_y[CW-1];
            r_s1_zn <= i_normal_z[CW-1];
            r_s1_sg <= i_bitangent_negative;
        end
    end

    // stage 2: squares, l1 norm, folded magnitudes
    logic [2*CW-1:0] r_s2_sqx, r_s2_sqy, r_s2_sqz;
    logic [LW-1:0] r_s2_l1, r_s2_mx, r_s2_my;
    logic r_s2_nx, r_s2_ny, r_s2_sg;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_sqx <= r_s1_ax * r_s1_ax;
            r_s2_sqy <= r_s1_ay * r_s1_ay;
            r_s2_sqz <= r_s1_az * r_s1_az;
            r_s2_l1  <= LW'(r_s1_ax) + LW'(r_s1_ay) + LW'(r_s1_az);
            r_s2_mx  <= r_s1_zn ? LW'(r_s1_ax) + LW'(r_s1_az) : LW'(r_s1_ax);
            r_s2_my  <= r_s1_zn ? LW'(r_s1_ay) + LW'(r_s1_az) : LW'(r_s1_ay);
            r_s2_nx  <= r_s1_nx;
            r_s2_ny  <= r_s1_ny;
            r_s2_sg  <= r_s1_sg;
        end
    end

    // stage 3: threshold test and numerators
    logic [SQW-1:0] sq_sum;
    assign sq_sum = SQW'(r_s2_sqx) + SQW'(r_s2_sqy) + SQW'(r_s2_sqz);

    logic [NW-1:0] r_s3_numx, r_s3_numy, r_s3_d;
    logic r_s3_dg, r_s3_sg;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s3_dg   <= (r_s2_l1 == '0) || (sq_sum < SQW'(r_min_sq));
            r_s3_numx <= r_s2_nx ? NW'(r_s2_l1) - NW'(r_s2_mx) : NW'(r_s2_l1) + NW'(r_s2_mx);
            r_s3_numy <= r_s2_ny ? NW'(r_s2_l1) - NW'(r_s2_my) : NW'(r_s2_l1) + NW'(r_s2_my);
            r_s3_d    <= {r_s2_l1, 1'b0};
            r_s3_sg   <= r_s2_sg;
        end
    end

    // stage 4: dividend = num * levels, split into first remainder and low bits
    logic wide;
    logic [DVW-1:0] dvx, dvy;
    assign wide = (r_mode == MODE_OCT32);
    assign dvx = wide ? (DVW'(r_s3_numx) << 16) - DVW'(r_s3_numx)
                      : (DVW'(r_s3_numx) << 8) - DVW'(r_s3_numx);
    assign dvy = wide ? (DVW'(r_s3_numy) << 16) - DVW'(r_s3_numy)
                      : (DVW'(r_s3_numy) << 8) - DVW'(r_s3_numy);

    logic [NW-1:0] r_remx [NSTG+1];
    logic [NW-1:0] r_remy [NSTG+1];
    logic [QW-1:0] r_lowx [NSTG+1];
    logic [QW-1:0] r_lowy [NSTG+1];
    logic [QW-1:0] r_qx [NSTG+1];
    logic [QW-1:0] r_qy [NSTG+1];
    logic [NW-1:0] r_d [NSTG+1];
    logic r_dg [NSTG+1];
    logic r_sg [NSTG+1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_remx[0] <= dvx[DVW-1:QW];
            r_remy[0] <= dvy[DVW-1:QW];
            r_lowx[0] <= dvx[QW-1:0];
            r_lowy[0] <= dvy[QW-1:0];
            r_qx[0]   <= '0;
            r_qy[0]   <= '0;
            r_d[0]    <= r_s3_d;
            r_dg[0]   <= r_s3_dg;
            r_sg[0]   <= r_s3_sg;
        end
    end

    // divider stages, restoring, two quotient bits each
    for (genvar s = 0; s < NSTG; s++) begin : g_div
        logic [NW-1:0] n_remx, n_remy;
        logic [QW-1:0] n_lowx, n_lowy, n_qx, n_qy;
        logic [RW-1:0] tx, ty;

        always_comb begin
            n_remx = r_remx[s];
            n_remy = r_remy[s];
            n_lowx = r_lowx[s];
            n_lowy = r_lowy[s];
            n_qx   = r_qx[s];
            n_qy   = r_qy[s];
            tx     = '0;
            ty     = '0;
            for (int j = 0; j < QBITS_PER_STAGE; j++) begin
                tx = {n_remx, n_lowx[QW-1]};
                ty = {n_remy, n_lowy[QW-1]};
                n_lowx = n_lowx << 1;
                n_lowy = n_lowy << 1;
                if (tx >= RW'(r_d[s])) begin
                    n_remx = NW'(tx - RW'(r_d[s]));
                    n_qx = {n_qx[QW-2:0], 1'b1};
                end else begin
                    n_remx = NW'(tx);
                    n_qx = {n_qx[QW-2:0], 1'b0};
                end
                if (ty >= RW'(r_d[s])) begin
                    n_remy = NW'(ty - RW'(r_d[s]));
                    n_qy = {n_qy[QW-2:0], 1'b1};
                end else begin
                    n_remy = NW'(ty);
                    n_qy = {n_qy[QW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_remx[s+1] <= n_remx;
                r_remy[s+1] <= n_remy;
                r_lowx[s+1] <= n_lowx;
                r_lowy[s+1] <= n_lowy;
                r_qx[s+1]   <= n_qx;
                r_qy[s+1]   <= n_qy;
                r_d[s+1]    <= r_d[s];
                r_dg[s+1]   <= r_dg[s];
                r_sg[s+1]   <= r_sg[s];
            end
        end
    end

    // output packing
    logic [QW-1:0] qx, qy;
    logic tsign;
    assign qx = r_dg[NSTG] ? '0 : r_qx[NSTG];
    assign qy = r_dg[NSTG] ? '0 : r_qy[NSTG];
    assign tsign = (r_mode == MODE_TANGENT) && r_sg[NSTG];

    always_comb begin
        if (wide) begin
            o_packed_code = {qy, qx};
        end else begin
            o_packed_code = {15'd0, tsign, qy[7:0], qx[7:0]};
        end
    end
    assign o_degenerate = r_dg[NSTG];

    `ASSERT_IMP(a_degen_zero, i_clk, i_rst_n, o_out_valid && o_degenerate,
        o_packed_code[15:0] == 16'd0 && (wide || o_packed_code[31:17] == 15'd0),
        "degenerate result carries a nonzero code")
    `ASSERT_IMP(a_narrow_range, i_clk, i_rst_n, o_out_valid && !wide,
        o_packed_code[31:17] == 15'd0, "narrow code exceeds 17 bits")
    `ASSERT_IMP(a_stall_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready,
        ##1 (o_out_valid && $stable(r_qx[NSTG]) && $stable(r_dg[NSTG])),
        "stalled result changed")
    `ASSERT_CLK(a_rem_bound, i_clk, i_rst_n,
        !r_vld[NS-1] || r_dg[NSTG] || (r_remx[NSTG] < r_d[NSTG]),
        "divider remainder out of range")
endmodule

// ----- tb/tb_top.sv -----
// self-checking testbench for the octahedral normal encoder
// depends on one_pkg and the octahedral_normal_encode rtl
module tb_top;
    import one_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    class normal_code_scoreboard;
        logic [1:0]  mode;
        logic [31:0] min_len_sq;
        logic [31:0] code_q[$];
        logic        degen_q[$];
        int          mismatches;

        function new();
            mode = MODE_RST;
            min_len_sq = MIN_LEN_SQ_RST;
            mismatches = 0;
        endfunction

        function automatic logic [63:0] quantize_axis(bit neg, longint unsigned m,
                                                      longint unsigned l1,
                                                      longint unsigned levels);
            longint unsigned num;
            longint unsigned q;
            num = neg ? l1 - m : l1 + m;
            q = (num * levels) / (2 * l1);
            return (q > levels) ? levels : q;
        endfunction

        function void note_vector(logic [15:0] x, logic [15:0] y, logic [15:0] z,
                                  logic bn);
            longint sx, sy, sz;
            longint unsigned ax, ay, az, sq, l1, levels, mx, my;
            logic [63:0] code;
            logic degen;
            bit wide;
            sx = $signed(x);
            sy = $signed(y);
            sz = $signed(z);
            ax = sx < 0 ? -sx : sx;
            ay = sy < 0 ? -sy : sy;
            az = sz < 0 ? -sz : sz;
            sq = ax * ax + ay * ay + az * az;
            l1 = ax + ay + az;
            wide = (mode == MODE_OCT32);
            levels = wide ? 65535 : 255;
            code = 0;
            degen = 0;
            if (l1 == 0 || sq < min_len_sq) begin
                degen = 1;
            end else begin
                mx = ax;
                my = ay;
                if (sz < 0) begin
                    mx = ax + az;
                    my = ay + az;
                end
                code = quantize_axis(sx < 0, mx, l1, levels)
                     | (quantize_axis(sy < 0, my, l1, levels) << (wide ? 16 : 8));
            end
            if (mode == MODE_TANGENT) code[16] = code[16] | bn;
            code_q.push_back(code[31:0]);
            degen_q.push_back(degen);
        endfunction

        function void check_code(logic [31:0] code, logic degen);
            logic [31:0] ec;
            logic ed;
            if (code_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result code=%h", code);
                return;
            end
            ec = code_q.pop_front();
            ed = degen_q.pop_front();
            if (ec !== code || ed !== degen) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected code=%h degen=%b, got code=%h degen=%b",
                             ec, ed, code, degen);
            end
        endfunction
    endclass

    logic        i_clk, i_rst_n;
    logic        i_in_valid, o_in_ready;
    logic [15:0] i_normal_x, i_normal_y, i_normal_z;
    logic        i_bitangent_negative;
    logic        o_out_valid, i_out_ready;
    logic [31:0] o_packed_code;
    logic        o_degenerate;
    logic        i_cfg_valid, o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [31:0] i_cfg_data;

    normal_code_scoreboard sb;
    int  cycles;
    bit  stall_stretch;

    octahedral_normal_encode dut (.*);

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > 400000) begin
                $display("FAIL octahedral_normal_encode");
                $finish;
            end
        end
    end

    // receiver stall pattern, with quiet stretches
    always @(negedge i_clk) begin
        if (cycles % 512 == 0) stall_stretch <= 1'($urandom_range(0, 1));
        i_out_ready <= stall_stretch ? ($urandom_range(0, 3) != 0) : 1'b1;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_code(o_packed_code, o_degenerate);
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == REG_ENCODE_MODE) sb.mode = data[1:0];
        else sb.min_len_sq = data;
        @(negedge i_clk);
        i_cfg_valid <= 0;
    endtask

    task automatic send_vector(logic [15:0] x, logic [15:0] y, logic [15:0] z, logic bn);
        @(negedge i_clk);
        i_in_valid <= 1;
        i_normal_x <= x;
        i_normal_y <= y;
        i_normal_z <= z;
        i_bitangent_negative <= bn;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_vector(x, y, z, bn);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 0;
        while (sb.code_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic random_vectors(int n, int narrow);
        int k;
        logic [15:0] x, y, z;
        for (int i = 0; i < n; i++) begin
            x = 16'($urandom);
            y = 16'($urandom);
            z = 16'($urandom);
            if (narrow) begin
                x = $signed(x) >>> $urandom_range(0, 15);
                y = $signed(y) >>> $urandom_range(0, 15);
                z = $signed(z) >>> $urandom_range(0, 15);
            end
            if ($urandom_range(0, 9) == 0) x = 0;
            if ($urandom_range(0, 9) == 0) y = 0;
            send_vector(x, y, z, 1'($urandom_range(0, 1)));
            if ($urandom_range(0, 5) == 0) begin
                @(negedge i_clk);
                i_in_valid <= 0;
                k = $urandom_range(1, 6);
                repeat (k - 1) @(negedge i_clk);
            end
        end
    endtask

    logic [15:0] edge_vals[6] = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0001, 16'h4000};
    logic [31:0] thresholds[5] = '{32'd1, 32'd11, 32'd1000000, 32'd3221225472, 32'hffffffff};

    initial begin
        sb = new();
        stall_stretch = 0;
        i_rst_n = 0;
        i_in_valid = 0;
        i_normal_x = 0;
        i_normal_y = 0;
        i_normal_z = 0;
        i_bitangent_negative = 0;
        i_out_ready = 1;
        i_cfg_valid = 0;
        i_cfg_index = REG_ENCODE_MODE;
        i_cfg_data = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // directed: extremes, folds, zero and tiny vectors, in every mode
        for (int m = 0; m < 4; m++) begin
            write_reg(REG_ENCODE_MODE, m);
            send_vector(16'h0000, 16'h0000, 16'h0000, 1);
            send_vector(16'h0001, 16'h0001, 16'h0001, 1);
            send_vector(16'h7fff, 16'h8000, 16'h8000, 0);
            send_vector(16'h8000, 16'h7fff, 16'h7fff, 1);
            send_vector(16'h0000, 16'h0000, 16'h8000, 1);
            send_vector(16'h0000, 16'hffff, 16'hc000, 0);
            drain();
        end

        for (int t = 0; t < 5; t++) begin
            write_reg(REG_MIN_LEN_SQ, thresholds[t]);
            for (int m = 0; m < 4; m++) begin
                write_reg(REG_ENCODE_MODE, m);
                for (int a = 0; a < 6; a++)
                    send_vector(edge_vals[a], edge_vals[(a + m) % 6],
                                edge_vals[(a + t) % 6], a[0]);
                random_vectors((t == 1 || t == 2) ? 150 : 50, t != 1);
                drain();
            end
        end

        if (sb.mismatches == 0 && sb.code_q.size() == 0) begin
            $display("PASS octahedral_normal_encode");
        end else begin
            $display("FAIL octahedral_normal_encode");
        end
        $finish;
    end
endmodule

// ----- octahedral_normal_encode.f -----
+incdir+src
src/one_pkg.sv
src/octahedral_normal_encode.sv
tb/tb_top.sv
